>>> sv/gms_pkg.sv
// Shared constants and types for the greedy motif search block.
package gms_pkg;
  localparam int MaxK = 12;
  localparam int MaxT = 16;
  localparam int MaxLen = 256;
  localparam int StoreDepth = 4096;
  localparam int AddrW = 12;
  localparam int KW = 4;
  localparam int TW = 5;
  localparam int LW = 9;
  localparam int CntW = 5;
  localparam int ProdW = 64;
  localparam int ProfDepth = 4 * MaxK;
  localparam int ProfAW = 6;

  localparam logic [1:0] RegKmerLen = 2'd0;
  localparam logic [1:0] RegNumStrings = 2'd1;
  localparam logic [1:0] RegStringLen = 2'd2;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT,        // clear best starts, zero score accumulator
    CMD_SCORE_BEST,  // score pass over best starts (accumulate one read)
    CMD_NEW_CAND,    // current_starts[0] = i
    CMD_PROF_CLR,    // refill profile with ones, zero best product
    CMD_PROF_ADD,    // add one base into profile
    CMD_PROD_MUL,    // multiply running product by one count
    CMD_PROD_DONE,   // compare product to best
    CMD_SET_START,   // current_starts[row] = best pos
    CMD_SCORE_CUR,   // score pass over current starts
    CMD_COMMIT       // compare score, maybe copy
  } cmd_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [3:0]      row;   // string index
    logic [8:0]      pos;   // position (p or i)
    logic [3:0]      col;   // column c
    logic            first; // first element of a pass
    logic            last;  // column done, fold its score
  } ctl_t;

  typedef struct packed {
    logic [7:0] start;
    logic [7:0] score;
  } sts_t;
endpackage

>>> sv/gms_datapath.sv
// Datapath: DNA store, start arrays, profile counts, product and score units.
module gms_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [gms_pkg::AddrW-1:0] wr_addr,
  input  logic [1:0]           wr_base,
  input  logic [gms_pkg::LW-1:0] eff_len,
  input  logic [gms_pkg::TW-1:0] eff_t,
  input  gms_pkg::ctl_t        ctl,
  input  logic [3:0]           out_row,
  output gms_pkg::sts_t        sts
);
  import gms_pkg::*;

  logic [1:0] dna_store [StoreDepth];
  logic [1:0] rd_base;
  logic [7:0] current_starts [MaxT];
  logic [7:0] best_starts [MaxT];
  logic [CntW-1:0] profile_counts [ProfDepth];
  logic [ProfDepth-1:0] prof_valid;
  logic [ProfAW-1:0] prof_rd_addr, prof_addr_q;
  logic [CntW-1:0] prof_q, prof_wdata;
  logic prof_valid_q, prof_we;
  logic [ProdW-1:0] prod, best_product;
  logic [7:0] best_pos;
  logic [7:0] best_score, acc_score;
  logic [TW-1:0] cnt [4];
  ctl_t ctl_q, ctl_qq;
  logic [7:0] start_sel;
  logic [AddrW-1:0] rd_addr;
  logic [TW-1:0] mx;
  logic [7:0] col_score;
  logic [CntW-1:0] pc;

  // Address of the base used by the command: row*L + start + col.
  always_comb begin
    unique case (ctl.cmd)
      CMD_SCORE_BEST: start_sel = best_starts[ctl.row];
      CMD_PROF_ADD, CMD_SCORE_CUR: start_sel = current_starts[ctl.row];
      default: start_sel = ctl.pos[7:0];
    endcase
    rd_addr = AddrW'(ctl.row * eff_len) + AddrW'(start_sel) + AddrW'(ctl.col);
  end

  always_ff @(posedge clk) begin
    if (wr_en) dna_store[wr_addr] <= wr_base;
    rd_base <= dna_store[rd_addr];
  end

  always_comb begin
    mx = cnt[0];
    for (int b = 1; b < 4; b++) if (cnt[b] > mx) mx = cnt[b];
    col_score = 8'(eff_t - mx);
    // Profile entry of the base just read from the store, in the column of its command.
    prof_rd_addr = ProfAW'(rd_base) * ProfAW'(MaxK) + ProfAW'(ctl_q.col);
    // Entries not written since the last refill count as one.
    pc = prof_valid_q ? prof_q : CntW'(1);
    prof_we = (ctl_qq.cmd == CMD_PROF_ADD);
    prof_wdata = pc + CntW'(1);
  end

  // Profile memory: registered read, one write a cycle. A write to the entry
  // being read in the same cycle is passed straight to the read register.
  always_ff @(posedge clk) begin
    if (prof_we) profile_counts[prof_addr_q] <= prof_wdata;
    prof_addr_q <= prof_rd_addr;
    if (prof_we && (prof_addr_q == prof_rd_addr)) begin
      prof_q <= prof_wdata;
      prof_valid_q <= 1'b1;
    end else begin
      prof_q <= profile_counts[prof_rd_addr];
      prof_valid_q <= prof_valid[prof_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
      ctl_qq <= '0;
      prof_valid <= '0;
    end else begin
      ctl_q <= ctl;
      ctl_qq <= ctl_q;
      if (ctl.cmd == CMD_PROF_CLR) prof_valid <= '0;
      else if (prof_we) prof_valid[prof_addr_q] <= 1'b1;
    end
    if (ctl.cmd == CMD_INIT) begin
      for (int j = 0; j < MaxT; j++) best_starts[j] <= '0;
      acc_score <= '0;
    end
    if (ctl.cmd == CMD_NEW_CAND) begin
      current_starts[0] <= ctl.pos[7:0];
      acc_score <= '0;
    end
    if (ctl.cmd == CMD_PROF_CLR) begin
      best_product <= '0;
      best_pos <= '0;
    end
    if (ctl.cmd == CMD_SET_START) current_starts[ctl.row] <= best_pos;
    // Registered stage: act on the base read for the command now held in ctl_q.
    unique case (ctl_q.cmd)
      CMD_SCORE_BEST, CMD_SCORE_CUR: begin
        if (ctl_q.first) begin
          for (int b = 0; b < 4; b++) cnt[b] <= (rd_base == 2'(b)) ? TW'(1) : '0;
        end else begin
          cnt[rd_base] <= cnt[rd_base] + TW'(1);
        end
      end
      default: ;
    endcase
    // Second stage: the profile count of that base is now available.
    if (ctl_qq.cmd == CMD_PROD_MUL) begin
      if (ctl_qq.first) prod <= ProdW'(pc);
      else prod <= prod * ProdW'(pc);
    end
    // Product done: keep a strictly larger product. Column done: fold into score (cnt stable by then).
    if ((ctl.cmd == CMD_PROD_DONE) && (prod > best_product)) begin
      best_product <= prod;
      best_pos <= ctl.pos[7:0];
    end
    if (ctl.cmd == CMD_COMMIT) begin
      if (ctl.first) begin
        best_score <= acc_score + col_score;
      end else if (acc_score + col_score < best_score) begin
        best_score <= acc_score + col_score;
        for (int j = 0; j < MaxT; j++) best_starts[j] <= current_starts[j];
      end
    end else if (ctl.last && ctl.cmd == CMD_NONE) begin
      acc_score <= acc_score + col_score;
    end
  end

  assign sts.start = best_starts[out_row];
  assign sts.score = best_score;
endmodule

>>> sv/gms_ctrl.sv
// Controller: load counter and search sequencer issuing datapath commands.
module gms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 wr_en,
  output logic [gms_pkg::AddrW-1:0] wr_addr,
  input  logic [gms_pkg::KW-1:0] eff_k,
  input  logic [gms_pkg::TW-1:0] eff_t,
  input  logic [gms_pkg::LW-1:0] eff_len,
  output gms_pkg::ctl_t        ctl,
  output logic [3:0]           out_row,
  input  gms_pkg::sts_t        sts,
  output logic                 strobe,
  output logic [3:0]           string_index,
  output logic [7:0]           motif_start,
  output logic [7:0]           motif_score,
  output logic                 last_motif
);
  import gms_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_SC_RD, S_SC_GAP, S_SC_COL, S_CAND, S_PCLR, S_PADD,
    S_PMUL, S_PGAP, S_PWAIT, S_PDONE, S_SETS, S_COMMIT, S_OUT
  } state_t;

  state_t state;
  logic [AddrW-1:0] load_count;
  logic scoring_best;
  logic [8:0] cand, pos;
  logic [3:0] row, rr, col;
  logic [8:0] last_pos;
  logic [12:0] total;

  assign total = 13'(eff_t * eff_len);
  assign last_pos = eff_len - 9'(eff_k);
  assign busy = (state != S_LOAD);
  assign wr_en = start && !busy;
  assign wr_addr = load_count;
  assign out_row = rr;

  always_comb begin
    ctl = '0;
    ctl.row = rr;
    ctl.col = col;
    ctl.pos = pos;
    unique case (state)
      S_INIT: ctl.cmd = CMD_INIT;
      S_SC_RD: begin
        ctl.cmd = scoring_best ? CMD_SCORE_BEST : CMD_SCORE_CUR;
        ctl.first = (rr == '0);
      end
      S_SC_COL: begin
        ctl.cmd = CMD_NONE;
        ctl.last = (col != 4'(eff_k - 1'b1));
        if (col == 4'(eff_k - 1'b1)) begin
          ctl.cmd = CMD_COMMIT;
          ctl.first = scoring_best;
        end
      end
      S_CAND: begin ctl.cmd = CMD_NEW_CAND; ctl.pos = cand; end
      S_PCLR: ctl.cmd = CMD_PROF_CLR;
      S_PADD: ctl.cmd = CMD_PROF_ADD;
      S_PMUL: begin
        ctl.cmd = CMD_PROD_MUL; ctl.row = row; ctl.first = (col == '0);
      end
      S_PDONE: ctl.cmd = CMD_PROD_DONE;
      S_SETS: begin ctl.cmd = CMD_SET_START; ctl.row = row; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; load_count <= '0; strobe <= 1'b0;
      rr <= '0; col <= '0; pos <= '0; row <= '0; cand <= '0; scoring_best <= 1'b0;
      string_index <= '0; motif_start <= '0; motif_score <= '0; last_motif <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_LOAD: if (start) begin
          if (13'(load_count) + 13'd1 < total) load_count <= load_count + 1'b1;
          else begin load_count <= '0; state <= S_INIT; end
        end
        S_INIT: begin
          scoring_best <= 1'b1; rr <= '0; col <= '0; state <= S_SC_RD;
        end
        S_SC_RD: if (5'(rr) + 5'd1 < eff_t) rr <= rr + 1'b1; else state <= S_SC_GAP;
        S_SC_GAP: state <= S_SC_COL;
        S_SC_COL: begin
          rr <= '0;
          if (col == 4'(eff_k - 1'b1)) begin
            col <= '0;
            if (scoring_best) begin
              scoring_best <= 1'b0; cand <= '0; state <= S_CAND;
            end else if (cand == last_pos) begin
              rr <= '0; state <= S_OUT;
            end else begin
              cand <= cand + 1'b1; state <= S_CAND;
            end
          end else begin
            col <= col + 1'b1; state <= S_SC_RD;
          end
        end
        S_CAND: begin
          row <= 4'd1; rr <= '0; col <= '0; pos <= '0;
          state <= (eff_t > 5'd1) ? S_PCLR : S_SC_RD;
        end
        S_PCLR: begin
          rr <= '0; col <= '0; pos <= '0;
          state <= S_PADD;
        end
        S_PADD: begin
          if (col != 4'(eff_k - 1'b1)) col <= col + 1'b1;
          else begin
            col <= '0;
            if (rr + 1'b1 < row) rr <= rr + 1'b1;
            else begin rr <= row; state <= S_PMUL; end
          end
        end
        S_PMUL: if (col != 4'(eff_k - 1'b1)) col <= col + 1'b1; else state <= S_PGAP;
        S_PGAP: state <= S_PWAIT;
        S_PWAIT: state <= S_PDONE;
        S_PDONE: begin
          col <= '0;
          if (pos == last_pos) state <= S_SETS;
          else begin pos <= pos + 1'b1; state <= S_PMUL; end
        end
        S_SETS: begin
          if (5'(row) + 5'd1 < eff_t) begin row <= row + 1'b1; state <= S_PCLR; end
          else begin rr <= '0; col <= '0; state <= S_SC_RD; end
        end
        S_OUT: begin
          strobe <= 1'b1;
          string_index <= rr;
          motif_start <= sts.start;
          motif_score <= sts.score;
          last_motif <= (5'(rr) + 5'd1 == eff_t);
          if (5'(rr) + 5'd1 == eff_t) state <= S_LOAD;
          else rr <= rr + 1'b1;
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

>>> sv/greedy_motif_search_pseudocount.sv
// Top level of the greedy motif search block with configuration registers.
// Usage: program kmer_len, num_strings and string_len over the APB-style
// port while the block is idle. Then send the bases of all strings, string
// 0 first, one per transfer: a transfer happens on a clock edge at which
// start is high and busy is low. When the final base is taken the block
// raises busy and runs the greedy search through one shared multiplier.
// After setup the initial set is scored. Each of the L-k+1 candidates
// then starts, builds for each later string r a profile from strings 0 to
// r-1, evaluates the product of every k-mer of string r and sets its start,
// and finally scores the candidate set; that product loop sets the run time.
// Afterwards one result per string is shown for exactly one cycle, marked
// by strobe, string 0 first, last_motif high on the final one; the
// receiver cannot stall them. busy then drops and loading may resume.
// Reset returns the registers to k=3, t=5, L=12 and clears the load count.
// Registers out of range are clamped before use.
module greedy_motif_search_pseudocount (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  base,
  output logic        strobe,
  output logic [3:0]  string_index,
  output logic [7:0]  motif_start,
  output logic [7:0]  motif_score,
  output logic        last_motif
);
  import gms_pkg::*;

  logic [KW-1:0] kmer_len;
  logic [TW-1:0] num_strings;
  logic [LW-1:0] string_len;
  logic [KW-1:0] eff_k;
  logic [TW-1:0] eff_t;
  logic [LW-1:0] eff_len;
  logic wr_en;
  logic [AddrW-1:0] wr_addr;
  ctl_t ctl;
  sts_t sts;
  logic [3:0] out_row;

  assign pready = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len <= KW'(3); num_strings <= TW'(5); string_len <= LW'(12);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegKmerLen: kmer_len <= pwdata[KW-1:0];
        RegNumStrings: num_strings <= pwdata[TW-1:0];
        RegStringLen: string_len <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      RegKmerLen: prdata = 32'(kmer_len);
      RegNumStrings: prdata = 32'(num_strings);
      RegStringLen: prdata = 32'(string_len);
      default: ;
    endcase
  end

  // Clamping of the register values; k never exceeds L.
  always_comb begin
    eff_t = (num_strings == '0) ? TW'(1) : (num_strings > TW'(MaxT) ? TW'(MaxT) : num_strings);
    eff_len = (string_len == '0) ? LW'(1)
            : (string_len > LW'(MaxLen) ? LW'(MaxLen) : string_len);
    eff_k = (kmer_len == '0) ? KW'(1) : (kmer_len > KW'(MaxK) ? KW'(MaxK) : kmer_len);
    if (LW'(eff_k) > eff_len) eff_k = KW'(eff_len);
  end

  gms_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .wr_en, .wr_addr, .eff_k, .eff_t, .eff_len,
    .ctl, .out_row, .sts, .strobe, .string_index, .motif_start, .motif_score,
    .last_motif
  );

  gms_datapath u_dp (
    .clk, .rst, .wr_en, .wr_addr, .wr_base(base), .eff_len, .eff_t, .ctl,
    .out_row, .sts
  );
endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the greedy motif search block with pseudocounts.
`timescale 1ns / 100ps

module testbench;
  import gms_pkg::*;

  localparam int CycleLimit = 1500000;
  localparam int ItemTarget = 470;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [1:0]  base;
  logic        strobe;
  logic [3:0]  string_index;
  logic [7:0]  motif_start;
  logic [7:0]  motif_score;
  logic        last_motif;

  greedy_motif_search_pseudocount dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .base(base),
    .strobe(strobe), .string_index(string_index), .motif_start(motif_start),
    .motif_score(motif_score), .last_motif(last_motif)
  );

  // One motif result as the block reports it.
  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] mstart;
    logic [7:0] mscore;
    logic       mlast;
  } motif_res_t;

  typedef enum {ROW_CFG, ROW_BASE} row_kind_t;

  // A directed row either programs all three registers or sends one base.
  // Rows with a literal expectation carry the single result they must cause.
  typedef struct {
    row_kind_t  kind;
    int         k_val;
    int         t_val;
    int         l_val;
    logic [1:0] b;
    bit         lit;
    motif_res_t res;
  } dir_row_t;

  localparam motif_res_t OnlyString = '{idx: 4'd0, mstart: 8'd0, mscore: 8'd0, mlast: 1'b1};
  localparam motif_res_t NoRes = '{idx: 4'd0, mstart: 8'd0, mscore: 8'd0, mlast: 1'b0};

  // A single string of length one always yields start 0 and score 0. Zero
  // register values clamp to the same shape. Later rows fall back on the
  // predictor, including an all-A set and a set where k exceeds L.
  dir_row_t dir_tab [] = '{
    '{ROW_CFG,  1, 1, 1, 2'd0, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd0, 1'b1, OnlyString},
    '{ROW_BASE, 0, 0, 0, 2'd1, 1'b1, OnlyString},
    '{ROW_BASE, 0, 0, 0, 2'd2, 1'b1, OnlyString},
    '{ROW_BASE, 0, 0, 0, 2'd3, 1'b1, OnlyString},
    '{ROW_CFG,  0, 0, 0, 2'd0, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd3, 1'b1, OnlyString},
    '{ROW_BASE, 0, 0, 0, 2'd2, 1'b1, OnlyString},
    '{ROW_CFG,  1, 2, 2, 2'd0, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd0, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd1, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd3, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd1, 1'b0, NoRes},
    '{ROW_CFG,  2, 2, 3, 2'd0, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd0, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd0, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd0, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd0, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd0, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd0, 1'b0, NoRes},
    '{ROW_CFG,  9, 2, 2, 2'd0, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd2, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd3, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd2, 1'b0, NoRes},
    '{ROW_BASE, 0, 0, 0, 2'd1, 1'b0, NoRes}
  };

  // Shadow of the block's registers and working state.
  logic [3:0]  kmer_reg;
  logic [4:0]  strings_reg;
  logic [8:0]  len_reg;
  logic [1:0]  dna_mem [StoreDepth];
  logic [11:0] loaded;
  int          cur_starts [MaxT];
  int          win_starts [MaxT];
  int          win_score;
  int          t_eff;
  int          l_eff;
  int          k_eff;

  motif_res_t  pending_motifs [$];
  int          items_sent;
  int          cycle_count;
  bit          failed;
  bit          quiet_stretch;

  // Clamp the raw register values the same way the block does before use.
  function automatic void clamp_sizes();
    t_eff = (strings_reg < 1) ? 1 : ((strings_reg > MaxT) ? MaxT : int'(strings_reg));
    l_eff = (len_reg < 1) ? 1 : ((len_reg > MaxLen) ? MaxLen : int'(len_reg));
    k_eff = (kmer_reg < 1) ? 1 : ((kmer_reg > MaxK) ? MaxK : int'(kmer_reg));
    if (k_eff > l_eff) k_eff = l_eff;
  endfunction

  function automatic int base_at(int s, int p);
    return int'(dna_mem[(s * l_eff + p) % StoreDepth]);
  endfunction

  // Mismatches to the consensus column by column.
  function automatic int consensus_misses(int starts [MaxT]);
    int cnt [4];
    int total;
    int top;
    total = 0;
    for (int c = 0; c < k_eff; c++) begin
      cnt = '{0, 0, 0, 0};
      top = 0;
      for (int s = 0; s < t_eff; s++) cnt[base_at(s, starts[s] + c)]++;
      for (int b = 0; b < 4; b++) if (cnt[b] > top) top = cnt[b];
      total += t_eff - top;
    end
    return total;
  endfunction

  // Profile from the rows already chosen, every count starting at one; the
  // first k-mer with the strictly greatest product wins.
  function automatic int likeliest_kmer(int row);
    int        counts [4][MaxK];
    longint unsigned prod;
    longint unsigned top_prod;
    int        pos;
    for (int b = 0; b < 4; b++)
      for (int c = 0; c < MaxK; c++) counts[b][c] = 1;
    for (int i = 0; i < row; i++)
      for (int c = 0; c < k_eff; c++) counts[base_at(i, cur_starts[i] + c)][c]++;
    top_prod = 0;
    pos = 0;
    for (int p = 0; p + k_eff <= l_eff; p++) begin
      prod = 1;
      for (int c = 0; c < k_eff; c++) prod = prod * counts[base_at(row, p + c)][c];
      if (prod > top_prod) begin
        top_prod = prod;
        pos = p;
      end
    end
    return pos;
  endfunction

  // Greedy search over every start in string 0. Only a strictly lower
  // score replaces the best set, which begins as the first k-mer everywhere.
  function automatic void greedy_search();
    int sc;
    for (int j = 0; j < MaxT; j++) win_starts[j] = 0;
    win_score = consensus_misses(win_starts);
    for (int i = 0; i + k_eff <= l_eff; i++) begin
      cur_starts[0] = i;
      for (int j = 1; j < t_eff; j++) cur_starts[j] = likeliest_kmer(j);
      sc = consensus_misses(cur_starts);
      if (sc < win_score) begin
        win_score = sc;
        for (int j = 0; j < t_eff; j++) win_starts[j] = cur_starts[j];
      end
    end
  endfunction

  // Store one accepted base and queue the motifs it causes, if any. The
  // search fires once load count plus one reaches t*L, which also covers a
  // load count already past a freshly shrunk total.
  function automatic void load_base(logic [1:0] b);
    motif_res_t r;
    clamp_sizes();
    dna_mem[loaded] = b;
    if (int'(loaded) + 1 < t_eff * l_eff) begin
      loaded = loaded + 12'd1;
    end else begin
      loaded = '0;
      greedy_search();
      for (int s = 0; s < t_eff; s++) begin
        r.idx = s[3:0];
        r.mstart = win_starts[s][7:0];
        r.mscore = win_score[7:0];
        r.mlast = (s + 1 == t_eff);
        pending_motifs.push_back(r);
      end
    end
  endfunction

  // Clock, cycle limit and timeout.
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("greedy_motif_search_pseudocount verification failed");
      $finish;
    end
  end

  // Result checker. Results cannot be held off, so every strobe is one
  // transfer and is compared against the oldest queued motif.
  always @(posedge clk) begin
    motif_res_t want;
    if (!rst && strobe) begin
      if (pending_motifs.size() == 0) begin
        $error("unexpected result: string_index %0d motif_start %0d", string_index,
               motif_start);
        failed <= 1'b1;
      end else begin
        want = pending_motifs.pop_front();
        if (string_index !== want.idx) begin
          $error("string_index expected %0d actual %0d", want.idx, string_index);
          failed <= 1'b1;
        end
        if (motif_start !== want.mstart) begin
          $error("motif_start expected %0d actual %0d", want.mstart, motif_start);
          failed <= 1'b1;
        end
        if (motif_score !== want.mscore) begin
          $error("motif_score expected %0d actual %0d", want.mscore, motif_score);
          failed <= 1'b1;
        end
        if (last_motif !== want.mlast) begin
          $error("last_motif expected %0d actual %0d", want.mlast, last_motif);
          failed <= 1'b1;
        end
      end
    end
  end

  // Program all three registers. Writes only happen once every queued motif
  // has come out and busy is low, plus a short settling pause. Back-to-back
  // writes keep psel high so it is never lowered and raised in one step.
  task automatic write_sizes(int k_val, int t_val, int l_val);
    logic [31:0] vals [3];
    logic [1:0]  idxs [3];
    start <= 1'b0;
    while (pending_motifs.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    vals = '{k_val, t_val, l_val};
    idxs = '{RegKmerLen, RegNumStrings, RegStringLen};
    for (int r = 0; r < 3; r++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idxs[r], 2'b00};
      pwdata <= vals[r];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    kmer_reg = k_val[3:0];
    strings_reg = t_val[4:0];
    len_reg = l_val[8:0];
  endtask

  // Present one base and hold it until the block takes it. Outside the quiet
  // stretch the sender sometimes pauses, about 14 times in a hundred.
  task automatic send_base(logic [1:0] b, bit lit, motif_res_t lit_res);
    if (!quiet_stretch && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    base <= b;
    do @(posedge clk); while (busy);
    load_base(b);
    if (lit) pending_motifs[pending_motifs.size() - 1] = lit_res;
    items_sent++;
    quiet_stretch = (items_sent >= 200 && items_sent < 300);
  endtask

  // Send enough bases to finish the current load, sometimes stopping short
  // so that the next register write lands in the middle of a load.
  task automatic load_strings();
    int remaining;
    int n;
    clamp_sizes();
    remaining = t_eff * l_eff - int'(loaded);
    if (remaining < 1) remaining = 1;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, remaining) : remaining;
    for (int i = 0; i < n; i++) send_base($urandom_range(0, 3), 1'b0, NoRes);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    base = '0;
    kmer_reg = 4'd3;
    strings_reg = 5'd5;
    len_reg = 9'd12;
    loaded = '0;
    for (int i = 0; i < StoreDepth; i++) dna_mem[i] = '0;
    items_sent = 0;
    cycle_count = 0;
    failed = 1'b0;
    quiet_stretch = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The reset sizes (k=3, t=5, L=12) are exercised before any write.
    load_strings();

    // Directed table.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG)
        write_sizes(dir_tab[i].k_val, dir_tab[i].t_val, dir_tab[i].l_val);
      else
        send_base(dir_tab[i].b, dir_tab[i].lit, dir_tab[i].res);
    end

    // Extremes: raw values past the limits clamp to k=12, t=1, L=256, then
    // sixteen short strings, then k larger than L.
    write_sizes(15, 0, 511);
    load_strings();
    write_sizes(2, 31, 3);
    load_strings();
    write_sizes(1, 16, 2);
    load_strings();
    write_sizes(12, 2, 5);
    load_strings();

    // Random sizes kept small so the search stays short; now and then the
    // registers are left alone or the load is cut short.
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 5) != 0)
        write_sizes($urandom_range(0, 15), $urandom_range(0, 5), $urandom_range(0, 10));
      load_strings();
    end

    start <= 1'b0;
    while (pending_motifs.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed && pending_motifs.size() == 0) begin
      $display("greedy_motif_search_pseudocount verification clean");
    end else begin
      $display("greedy_motif_search_pseudocount verification failed");
    end
    $finish;
  end
endmodule
